// ----- sv/imatp_pkg.sv -----
// Shared types and constants for the IPv4 / MAC address text parser.
// No dependencies; imported by the parser top level and its checker.
package imatp_pkg;

  localparam int MAX_LIST_ELEMENTS = 16;

  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;

  localparam logic [2:0] IPV4_OCTETS = 3'd4;
  localparam logic [2:0] MAC_OCTETS  = 3'd6;

  typedef enum logic [1:0] {
    REG_ADDRESS_MODE   = 2'd0,
    REG_LIST_SEPARATOR = 2'd1,
    REG_ELEMENT_LIMIT  = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_OCTET = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_TOO_MANY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [8:0]  acc;
    logic        seen;
    logic [2:0]  cnt;
    logic [47:0] shift;
    logic        eerr;
    status_t     lerr;
  } parse_state_t;

endpackage

// ----- sv/ip_mac_address_text_parser.sv -----
// Top level of the IPv4 / MAC address list text parser.
// Depends on imatp_pkg for codes, character constants and the parse state type.
//
// Usage:
//   Input channel (in_*): one character per beat, in_end_of_text on the last.
//   Result channel (out_*): one beat per element end (list separator, or the
//   final character), carrying the packed address, element index, element
//   valid flag, first list error so far and the end-of-string marker.
//   Configuration (cfg_*): index 0 address mode, 1 list separator, 2 element
//   limit; write only while the block is idle.
//   Timing: a result is on out_* in the cycle after the character beat that
//   ends its element. Throughput: one character per cycle while no result is
//   stalled; the character decode, octet accumulate and element check all sit
//   between the input handshake and the result register.
//   Stall: while a result waits for out_ready the input holds off
//   (in_ready low); when the receiver takes the result the next character
//   is taken in the same cycle.
//   Reset: clears parse state, drops any pending result and restores the
//   registers to IPv4 mode, separator ',' and limit 16.
module ip_mac_address_text_parser
  import imatp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_char,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_address_value,
  output logic [3:0]  out_element_number,
  output logic        out_element_valid,
  output logic [1:0]  out_list_status,
  output logic        out_last_result
);

  logic        address_mode_r;
  logic [7:0]  list_separator_r;
  logic [4:0]  element_limit_r;

  parse_state_t st_r, st_nxt;
  logic [4:0]   elem_cnt_r, elem_cnt_nxt;

  logic        out_valid_r;
  logic [47:0] out_addr_r, out_addr_nxt;
  logic [3:0]  out_num_r, out_num_nxt;
  logic        out_ev_r, out_ev_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_last_r, out_last_nxt;
  logic        emit;
  logic        accept;

  function automatic parse_state_t raise(parse_state_t s, status_t code);
    parse_state_t r;
    r = s;
    r.eerr = 1'b1;
    if (r.lerr == ST_OK) begin
      r.lerr = code;
    end
    return r;
  endfunction

  function automatic parse_state_t close_octet(parse_state_t s, logic by_delim,
                                               logic [2:0] need);
    parse_state_t r;
    r = s;
    if (!r.seen) begin
      r = raise(r, ST_BAD_OCTET);
    end else begin
      r.shift = {r.shift[39:0], r.acc[7:0]};
    end
    if (r.cnt < 3'd7) begin
      r.cnt = r.cnt + 3'd1;
    end
    if (by_delim && (r.cnt >= need)) begin
      r = raise(r, ST_BAD_COUNT);
    end
    r.acc  = '0;
    r.seen = 1'b0;
    return r;
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    parse_state_t s;
    logic        is_sep;
    logic [7:0]  delim;
    logic [2:0]  need;
    logic        is_digit;
    logic [3:0]  dval;
    logic [12:0] v;
    logic [4:0]  limit;
    logic        valid;
    s        = st_r;
    is_sep   = (in_text_char == list_separator_r);
    delim    = address_mode_r ? CHAR_COLON : CHAR_DOT;
    need     = address_mode_r ? MAC_OCTETS : IPV4_OCTETS;
    is_digit = 1'b0;
    dval     = '0;
    v        = '0;
    limit    = element_limit_r;
    valid    = 1'b0;
    emit     = 1'b0;
    elem_cnt_nxt   = elem_cnt_r;
    out_addr_nxt   = out_addr_r;
    out_num_nxt    = out_num_r;
    out_ev_nxt     = out_ev_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    if ((in_text_char >= CHAR_ZERO) && (in_text_char <= CHAR_NINE)) begin
      is_digit = 1'b1;
      dval     = in_text_char[3:0];
    end else if (address_mode_r && (in_text_char >= CHAR_LC_A)
                 && (in_text_char <= CHAR_LC_F)) begin
      is_digit = 1'b1;
      dval     = 4'(in_text_char - CHAR_LC_A) + 4'd10;
    end else if (address_mode_r && (in_text_char >= CHAR_UC_A)
                 && (in_text_char <= CHAR_UC_F)) begin
      is_digit = 1'b1;
      dval     = 4'(in_text_char - CHAR_UC_A) + 4'd10;
    end

    if (!is_sep) begin
      if (in_text_char == delim) begin
        s = close_octet(s, 1'b1, need);
      end else if (!is_digit) begin
        s = raise(s, ST_BAD_OCTET);
      end else begin
        if (address_mode_r) begin
          v = {s.acc, 4'b0000} + 13'(dval);
        end else begin
          v = 13'({s.acc, 3'b000}) + 13'({s.acc, 1'b0}) + 13'(dval);
        end
        if (v > 13'd255) begin
          v = 13'd256;
          s = raise(s, ST_BAD_OCTET);
        end
        s.acc  = v[8:0];
        s.seen = 1'b1;
      end
    end

    if (is_sep || in_end_of_text) begin
      emit = 1'b1;
      if ((s.cnt == 3'd0) && !s.seen && !s.eerr) begin
        s = raise(s, ST_BAD_COUNT);
      end else begin
        s = close_octet(s, 1'b0, need);
      end
      if (s.cnt != need) begin
        s = raise(s, ST_BAD_COUNT);
      end
      if (limit == 5'd0) begin
        limit = 5'd1;
      end else if (limit > 5'(MAX_LIST_ELEMENTS)) begin
        limit = 5'(MAX_LIST_ELEMENTS);
      end
      if (elem_cnt_r >= limit) begin
        s = raise(s, ST_TOO_MANY);
      end
      if (is_sep && in_end_of_text && (s.lerr == ST_OK)) begin
        s.lerr = ST_BAD_COUNT;
      end
      valid          = !s.eerr;
      out_addr_nxt   = valid ? s.shift : '0;
      out_num_nxt    = elem_cnt_r[3:0];
      out_ev_nxt     = valid;
      out_status_nxt = s.lerr;
      out_last_nxt   = in_end_of_text;
      s.acc   = '0;
      s.seen  = 1'b0;
      s.cnt   = '0;
      s.shift = '0;
      s.eerr  = 1'b0;
      if (in_end_of_text) begin
        elem_cnt_nxt = '0;
        s.lerr       = ST_OK;
      end else if (elem_cnt_r < 5'd31) begin
        elem_cnt_nxt = elem_cnt_r + 5'd1;
      end
    end
    st_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_mode_r   <= 1'b0;
      list_separator_r <= 8'd44;
      element_limit_r  <= 5'd16;
    end else if (cfg_write_en) begin
      case (reg_index_t'(cfg_index))
        REG_ADDRESS_MODE:   address_mode_r   <= cfg_data[0];
        REG_LIST_SEPARATOR: list_separator_r <= cfg_data;
        REG_ELEMENT_LIMIT:  element_limit_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      elem_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        st_r       <= st_nxt;
        elem_cnt_r <= elem_cnt_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_addr_r   <= out_addr_nxt;
      out_num_r    <= out_num_nxt;
      out_ev_r     <= out_ev_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_address_value  = out_addr_r;
  assign out_element_number = out_num_r;
  assign out_element_valid  = out_ev_r;
  assign out_list_status    = out_status_r;
  assign out_last_result    = out_last_r;

endmodule

// ----- sv/imatp_checker.sv -----
// Port-level checker for the address text parser, bound to the top level.
// Depends on imatp_pkg for the status codes.
module imatp_checker
  import imatp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_address_value,
  input logic        out_element_valid,
  input logic [1:0]  out_list_status
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_address_value)
      && $stable(out_list_status))
    else $error("result beat changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_element_valid |-> out_address_value == 48'd0)
    else $error("invalid element carries a nonzero address");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_valid_no_count_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_element_valid |-> out_list_status != ST_TOO_MANY)
    else $error("valid element under a too-many-elements status");

endmodule

bind ip_mac_address_text_parser imatp_checker u_imatp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_address_value (out_address_value),
  .out_element_valid (out_element_valid),
  .out_list_status   (out_list_status)
);

// ----- tb/tb_ip_mac_address_text_parser.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ip_mac_address_text_parser: directed and random address
// list text, each result beat checked against a built-in parse predictor.
// Depends on imatp_pkg and the parser RTL.
module tb_ip_mac_address_text_parser;
  import imatp_pkg::*;

  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam int         PHASE_BEATS = 180;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } text_beat_t;

  typedef struct {
    logic [47:0] addr;
    logic [3:0]  num;
    logic        ok;
    status_t     status;
    logic        eot;
  } elem_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  reg_index_t  cfg_index = REG_ADDRESS_MODE;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_char = '0;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [47:0] out_address_value;
  logic [3:0]  out_element_number;
  logic        out_element_valid;
  logic [1:0]  out_list_status;
  logic        out_last_result;

  // predictor registers and parse state
  logic        pm_mac;
  logic [7:0]  pm_sep;
  logic [4:0]  pm_limit;
  logic [8:0]  acc;
  logic        seen;
  logic [2:0]  oct_cnt;
  logic [47:0] shift_reg;
  logic [4:0]  elem_cnt;
  logic        elem_bad;
  status_t     str_status;

  text_beat_t   text_beats[$];
  elem_result_t expected_elems[$];
  logic [7:0]   text_buf[$];
  text_beat_t   next_beat;

  logic        gen_mac;
  logic [7:0]  gen_sep;
  int          gen_lim;
  logic        quiet = 1'b0;
  logic        hold_arm = 1'b0;
  int          hold_cycles = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          mismatches = 0;

  ip_mac_address_text_parser u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_char       (in_text_char),
    .in_end_of_text     (in_end_of_text),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_address_value  (out_address_value),
    .out_element_number (out_element_number),
    .out_element_valid  (out_element_valid),
    .out_list_status    (out_list_status),
    .out_last_result    (out_last_result)
  );

  always #5 clk = ~clk;

  function automatic void clear_element();
    acc = '0;
    seen = 1'b0;
    oct_cnt = '0;
    shift_reg = '0;
    elem_bad = 1'b0;
  endfunction

  function automatic void reset_parser();
    pm_mac = 1'b0;
    pm_sep = CHAR_COMMA;
    pm_limit = 5'd16;
    clear_element();
    elem_cnt = '0;
    str_status = ST_OK;
  endfunction

  function automatic void raise_fault(status_t code);
    elem_bad = 1'b1;
    if (str_status == ST_OK) str_status = code;
  endfunction

  function automatic logic [2:0] octets_req();
    return pm_mac ? MAC_OCTETS : IPV4_OCTETS;
  endfunction

  function automatic int digit_of(logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
    if (pm_mac && c >= CHAR_LC_A && c <= CHAR_LC_F) return int'(c - CHAR_LC_A) + 10;
    if (pm_mac && c >= CHAR_UC_A && c <= CHAR_UC_F) return int'(c - CHAR_UC_A) + 10;
    return -1;
  endfunction

  function automatic void close_octet(logic by_delim);
    if (!seen) raise_fault(ST_BAD_OCTET);
    else shift_reg = {shift_reg[39:0], acc[7:0]};
    if (oct_cnt < 3'd7) oct_cnt++;
    if (by_delim && oct_cnt >= octets_req()) raise_fault(ST_BAD_COUNT);
    acc = '0;
    seen = 1'b0;
  endfunction

  function automatic void parse_char(logic [7:0] c, logic eot);
    logic         is_sep;
    int           d;
    int           v;
    int           lim;
    elem_result_t r;
    is_sep = (c == pm_sep);
    if (!is_sep) begin
      if (c == (pm_mac ? CHAR_COLON : CHAR_DOT)) begin
        close_octet(1'b1);
      end else begin
        d = digit_of(c);
        if (d < 0) begin
          raise_fault(ST_BAD_OCTET);
        end else begin
          v = int'(acc) * (pm_mac ? 16 : 10) + d;
          if (v > 255) begin
            v = 256;
            raise_fault(ST_BAD_OCTET);
          end
          acc = 9'(v);
          seen = 1'b1;
        end
      end
      if (!eot) return;
    end
    if (oct_cnt == 0 && !seen && !elem_bad) raise_fault(ST_BAD_COUNT);
    else close_octet(1'b0);
    if (oct_cnt != octets_req()) raise_fault(ST_BAD_COUNT);
    lim = (pm_limit == 0) ? 1 : (pm_limit > MAX_LIST_ELEMENTS) ? MAX_LIST_ELEMENTS
                                                                : int'(pm_limit);
    if (int'(elem_cnt) >= lim) raise_fault(ST_TOO_MANY);
    if (is_sep && eot && str_status == ST_OK) str_status = ST_BAD_COUNT;
    r.ok = !elem_bad;
    r.addr = elem_bad ? '0 : shift_reg;
    r.num = elem_cnt[3:0];
    r.status = str_status;
    r.eot = eot;
    expected_elems.push_back(r);
    clear_element();
    if (eot) begin
      elem_cnt = '0;
      str_status = ST_OK;
    end else if (elem_cnt < 5'd31) begin
      elem_cnt++;
    end
  endfunction

  function automatic void check_result();
    elem_result_t e;
    if (expected_elems.size() == 0) begin
      if (mismatches < 10)
        $display("ERROR %0t: result beat with nothing expected, element %0d",
                 $time, out_element_number);
      mismatches++;
      return;
    end
    e = expected_elems.pop_front();
    if (out_address_value !== e.addr || out_element_number !== e.num ||
        out_element_valid !== e.ok || out_list_status !== e.status ||
        out_last_result !== e.eot) begin
      if (mismatches < 10)
        $display({"ERROR %0t: exp addr %h num %0d valid %0b status %0d last %0b",
                  " / got %h %0d %0b %0d %0b"},
                 $time, e.addr, e.num, e.ok, e.status, e.eot, out_address_value,
                 out_element_number, out_element_valid, out_list_status, out_last_result);
      mismatches++;
    end
  endfunction

  function automatic logic [7:0] hex_char(int d);
    if (d < 10) return 8'(CHAR_ZERO + d);
    return 8'(($urandom_range(0, 1) ? CHAR_LC_A : CHAR_UC_A) + d - 10);
  endfunction

  function automatic void add_octet(int v);
    if (gen_mac) begin
      if (v > 15 || $urandom_range(0, 1)) text_buf.push_back(hex_char(v / 16));
      text_buf.push_back(hex_char(v % 16));
    end else begin
      if ($urandom_range(0, 7) == 0) text_buf.push_back(CHAR_ZERO);
      if (v >= 100) text_buf.push_back(8'(CHAR_ZERO + v / 100));
      if (v >= 10) text_buf.push_back(8'(CHAR_ZERO + (v / 10) % 10));
      text_buf.push_back(8'(CHAR_ZERO + v % 10));
    end
  endfunction

  function automatic void add_bad_octet();
    case ($urandom_range(0, 3))
      0: begin
      end
      1: begin
        if (gen_mac) begin
          text_buf.push_back(hex_char($urandom_range(1, 15)));
          text_buf.push_back(hex_char($urandom_range(0, 15)));
          text_buf.push_back(hex_char($urandom_range(0, 15)));
        end else begin
          add_octet($urandom_range(256, 999));
        end
      end
      2: text_buf.push_back(8'($urandom_range(0, 255)));
      default: text_buf.push_back(8'(CHAR_LC_A + (gen_mac ? 6 : $urandom_range(0, 5))));
    endcase
  endfunction

  function automatic void add_element();
    int n;
    int kind;
    int bad_at;
    int i;
    n = gen_mac ? 6 : 4;
    kind = $urandom_range(0, 11);
    bad_at = -1;
    if (kind == 8) begin
      n++;
    end else if (kind == 9) begin
      n = $urandom_range(0, n - 1);
    end else if (kind == 10) begin
      bad_at = $urandom_range(0, n - 1);
    end else if (kind == 11) begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    for (i = 0; i < n; i++) begin
      if (i != 0) text_buf.push_back(gen_mac ? CHAR_COLON : CHAR_DOT);
      if (i == bad_at) add_bad_octet();
      else if ($urandom_range(0, 3) == 0) add_octet(255 * $urandom_range(0, 1));
      else add_octet($urandom_range(0, 255));
    end
  endfunction

  function automatic int flush_text();
    int i;
    int k;
    text_beat_t b;
    k = text_buf.size();
    for (i = 0; i < k; i++) begin
      b.ch = text_buf[i];
      b.eot = (i == k - 1);
      text_beats.push_back(b);
    end
    text_buf.delete();
    return k;
  endfunction

  function automatic int add_text_string();
    int n_el;
    int i;
    text_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 59))
        0: n_el = $urandom_range(30, 34);
        1, 2, 3, 4, 5, 6: n_el = $urandom_range(gen_lim, gen_lim + 2);
        default: n_el = $urandom_range(1, 4);
      endcase
      for (i = 0; i < n_el; i++) begin
        if (i != 0) text_buf.push_back(gen_sep);
        add_element();
      end
      if (text_buf.size() == 0 || $urandom_range(0, 7) == 0) text_buf.push_back(gen_sep);
    end
    return flush_text();
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (text_beats.size() != 0 || in_valid || expected_elems.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ADDRESS_MODE:   pm_mac = val[0];
      REG_LIST_SEPARATOR: pm_sep = val;
      REG_ELEMENT_LIMIT:  pm_limit = val[4:0];
      default: begin
      end
    endcase
  endtask

  task automatic run_phase(logic mac, logic [7:0] sep, logic [4:0] lim);
    int count;
    wait_idle();
    write_reg(REG_ADDRESS_MODE, {7'd0, mac});
    write_reg(REG_LIST_SEPARATOR, sep);
    write_reg(REG_ELEMENT_LIMIT, {3'd0, lim});
    @(posedge clk);
    cfg_write_en <= 1'b0;
    gen_mac = mac;
    gen_sep = sep;
    gen_lim = (lim == 0) ? 1 : (lim > MAX_LIST_ELEMENTS) ? MAX_LIST_ELEMENTS : int'(lim);
    @(negedge clk);
    count = 0;
    while (count < PHASE_BEATS) count += add_text_string();
  endtask

  // driver: advance the predictor on each accepted beat, then offer the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_char(in_text_char, in_end_of_text);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (text_beats.size() != 0) begin
          next_beat = text_beats.pop_front();
          in_valid <= 1'b1;
          in_text_char <= next_beat.ch;
          in_end_of_text <= next_beat.eot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (hold_arm) begin
      hold_cycles <= 400;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    string dir_text;
    int    i;
    reset_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    dir_text = "255.0.9.1,,256.,1.2.3.4.,";
    for (i = 0; i < dir_text.len(); i++) text_buf.push_back(dir_text[i]);
    text_buf.push_back(8'h00);
    text_buf.push_back(8'hff);
    text_buf.push_back(CHAR_COMMA);
    void'(flush_text());
    run_phase(1'b0, CHAR_COMMA, 5'd16);
    run_phase(1'b1, CHAR_COMMA, 5'd16);
    @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    run_phase(1'b1, 8'h00, 5'd1);
    run_phase(1'b0, 8'hff, 5'd3);
    run_phase(1'b0, CHAR_DOT, 5'd0);
    run_phase(1'b1, 8'($urandom_range(0, 255)), 5'd20);
    run_phase(1'b0, CHAR_SPACE, 5'd2);
    run_phase(1'b0, CHAR_SEMI, 5'd5);
    wait_idle();
    quiet = 1'b1;
    run_phase(1'b1, CHAR_COMMA, 5'd16);
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_ip_mac_address_text_parser: PASS");
    end else begin
      $display("tb_ip_mac_address_text_parser: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_ip_mac_address_text_parser: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/imatp_pkg.sv
sv/ip_mac_address_text_parser.sv
sv/imatp_checker.sv
tb/tb_ip_mac_address_text_parser.sv
